>>> hdl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority ready queue: depth, count width,
// operation and status codes, slot and control records.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } prq_status_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } prq_entry_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic       enq;
        logic       deq;
        prq_entry_t new_entry;
    } prq_ctrl_t;

endpackage

>>> hdl/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue
// Ready queue sorted by priority, highest first, ties in arrival order,
// built as a row of slot cells with a shared fill count.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser
//  s_       in   [7:0] task_id, [15:8] task_priority     [0] op
//  m_       out  [7:0] out_id, [15:8] out_priority,      [0] out_valid,
//                [20:16] occupancy                       [2:1] status
//
//  One word per cycle while s_tready is high: every cell compares its slot
//  with the incoming priority in parallel and shifts in the same cycle, so the
//  result stands in the output register in the cycle after acceptance.
//  Reset clears the fill count and the output valid; slots need no clearing.
//  s_tready stays high while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module priority_ready_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // task_id, task_priority
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_id, out_priority, occupancy, zero pad
    output logic [2:0]  m_tuser    // out_valid, status
);
    import prq_pkg::*;

    logic             accept;
    logic             full;
    logic             empty;
    prq_ctrl_t        ctrl;
    prq_entry_t       entry_arr [QUEUE_DEPTH];
    logic             take_arr  [QUEUE_DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic [7:0]       out_id_reg;
    logic [7:0]       out_id_next;
    logic [7:0]       out_prio_reg;
    logic [7:0]       out_prio_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    prq_status_t      status_reg;
    prq_status_t      status_next;
    logic [OCC_W-1:0] occ_reg;
    logic [CNT_W+OCC_W-1:0] count_wide;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        ctrl.enq          = 1'b0;
        ctrl.deq          = 1'b0;
        ctrl.new_entry.id   = s_tdata[7:0];
        ctrl.new_entry.prio = s_tdata[15:8];
        count_next        = count_reg;
        out_valid_next    = 1'b0;
        out_id_next       = '0;
        out_prio_next     = '0;
        status_next       = STATUS_OK;
        unique case (s_tuser[0])
            OP_ENQ: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctrl.enq   = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQ: begin
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    ctrl.deq       = accept;
                    count_next     = count_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_id_next    = entry_arr[0].id;
                    out_prio_next  = entry_arr[0].prio;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic       occupied;
            logic       left_take;
            prq_entry_t left_entry;
            prq_entry_t right_entry;

            assign occupied = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign left_take  = 1'b0;
                assign left_entry = '0;
            end else begin : g_inner
                assign left_take  = take_arr[gi-1];
                assign left_entry = entry_arr[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign right_entry = entry_arr[gi];
            end else begin : g_body
                assign right_entry = entry_arr[gi+1];
            end

            prq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occupied),
                .left_take   (left_take),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_arr[gi]),
                .take        (take_arr[gi])
            );
        end
    endgenerate

    // Occupancy carries the low bits of the count.
    assign count_wide = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_prio_reg  <= out_prio_next;
            status_reg    <= status_next;
            occ_reg       <= count_wide[OCC_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, out_prio_reg, out_id_reg};
    assign m_tuser  = {status_reg, out_valid_reg};

endmodule

>>> hdl/prq_cell.sv
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted row. Compares its priority with the incoming task,
// then holds, loads the new task, takes its left neighbor's slot on an
// insert, or takes its right neighbor's slot on a removal.
// ----------------------------------------------------------------------------
module prq_cell (
    input  logic               aclk,
    input  prq_pkg::prq_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_take,
    input  prq_pkg::prq_entry_t left_entry,
    input  prq_pkg::prq_entry_t right_entry,
    output prq_pkg::prq_entry_t entry,
    output logic               take
);
    import prq_pkg::*;

    prq_entry_t entry_reg;
    prq_entry_t entry_next;

    // Free slots and slots of strictly lower priority give way.
    assign take  = !occupied || (entry_reg.prio < ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq && take) begin
            entry_next = left_take ? left_entry : ctrl.new_entry;
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives priority_ready_queue with enqueue and dequeue words under random
// idling on both channels. A scoreboard keeps its own sorted copy of the
// queue, works out every dispatch word and checks each result against it.
// ----------------------------------------------------------------------------
module testbench;
    import prq_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned RANDOM_WORDS = 400;

    typedef struct packed {
        logic             valid;
        logic [7:0]       id;
        logic [7:0]       prio;
        prq_status_t      status;
        logic [OCC_W-1:0] occ;
    } dispatch_t;

    class dispatch_checker;
        prq_entry_t      slots[QUEUE_DEPTH];
        int unsigned     task_count;
        dispatch_t       expected_dispatches[$];
        int unsigned     mismatches;

        function new();
            task_count = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted request to the shadow queue and queue its dispatch word.
        function void note_request(logic op, prq_entry_t req);
            dispatch_t   d;
            int unsigned pos;
            int unsigned i;
            d = '0;
            d.status = STATUS_OK;
            if (op == OP_ENQ) begin
                if (task_count >= QUEUE_DEPTH) begin
                    d.status = STATUS_FULL;
                end else begin
                    // land behind every task of equal or higher priority
                    pos = 0;
                    while (pos < task_count && slots[pos].prio >= req.prio) pos++;
                    for (i = task_count; i > pos; i--) slots[i] = slots[i - 1];
                    slots[pos] = req;
                    task_count++;
                end
            end else if (task_count == 0) begin
                d.status = STATUS_EMPTY;
            end else begin
                d.valid = 1'b1;
                d.id    = slots[0].id;
                d.prio  = slots[0].prio;
                for (i = 1; i < task_count; i++) slots[i - 1] = slots[i];
                task_count--;
            end
            d.occ = task_count[OCC_W-1:0];
            expected_dispatches.push_back(d);
        endfunction

        function void check_dispatch(logic [23:0] tdata, logic [2:0] tuser);
            dispatch_t got;
            dispatch_t want;
            got.valid  = tuser[0];
            got.status = prq_status_t'(tuser[2:1]);
            got.id     = tdata[7:0];
            got.prio   = tdata[15:8];
            got.occ    = tdata[20:16];
            if (expected_dispatches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word valid=%0b id=%0d prio=%0d status=%0d occ=%0d",
                             $time, got.valid, got.id, got.prio, got.status, got.occ);
                return;
            end
            want = expected_dispatches.pop_front();
            if (got.valid != want.valid || got.id != want.id || got.prio != want.prio ||
                got.status != want.status || got.occ != want.occ) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp valid=%0b id=%0d prio=%0d status=%0d occ=%0d %s",
                             $time, want.valid, want.id, want.prio, want.status, want.occ,
                             $sformatf("got valid=%0b id=%0d prio=%0d status=%0d occ=%0d",
                                       got.valid, got.id, got.prio, got.status, got.occ));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    dispatch_checker sb;
    int unsigned     words_taken;
    int unsigned     idle_cycles;

    priority_ready_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic op, input logic [7:0] id, input logic [7:0] prio,
                             input int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], '{id: s_tdata[7:0], prio: s_tdata[15:8]});
            if (m_tvalid && m_tready) begin
                sb.check_dispatch(m_tdata, m_tuser);
                words_taken++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("priority_ready_queue verification failed");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold to fill the block.
    initial begin
        bit          held;
        int unsigned gap;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && words_taken >= 120) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    initial begin
        int unsigned n;
        int unsigned enq_pct;
        bit          no_idle;
        logic        op;
        logic [7:0]  prio;
        sb          = new();
        words_taken = 0;
        idle_cycles = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ENQ;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // dequeue from empty, extremes and ties, fill to capacity, overflow, drain a few
        send_word(OP_DEQ, 8'hFF, 8'hFF, 0);
        send_word(OP_ENQ, 8'h00, 8'h00, 0);
        send_word(OP_ENQ, 8'hFF, 8'hFF, 0);
        send_word(OP_ENQ, 8'h5A, 8'h80, 1);
        send_word(OP_ENQ, 8'hA5, 8'h80, 0);
        send_word(OP_ENQ, 8'h11, 8'hFF, 0);
        send_word(OP_ENQ, 8'h22, 8'h00, 2);
        for (n = 0; n < 10; n++)
            send_word(OP_ENQ, 8'(8'h30 + n), 8'((n * 37) & 8'hFF), 0);
        send_word(OP_ENQ, 8'h33, 8'h40, 0);
        for (n = 0; n < 5; n++)
            send_word(OP_DEQ, 8'h00, 8'h00, n % 2);

        // bursts with a drifting enqueue bias so the queue swings from empty to full
        n = 0;
        while (n < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(10, 30)) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                // a narrow priority pool gives many ties
                if ($urandom_range(0, 1) == 0)
                    prio = 8'($urandom_range(0, 3) * 85);
                else
                    prio = 8'($urandom_range(0, 255));
                send_word(op, 8'($urandom_range(0, 255)), prio, no_idle ? 0 : pick_gap());
                n++;
            end
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted word before draining
        @(posedge aclk);

        while (sb.expected_dispatches.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_dispatches.size() == 0)
            $display("priority_ready_queue verification clean");
        else
            $display("priority_ready_queue verification failed");
        $finish;
    end

endmodule
